// ----- rtl/cfp_pkg.sv -----
// Shared types, constants and helpers for the command frame parser.
`timescale 1ns / 1ps
package cfp_pkg;

  // Frame and acknowledge bytes
  localparam logic [7:0] HDR0_BYTE     = 8'hAA;
  localparam logic [7:0] HDR1_BYTE     = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT    = 8'hF1;
  localparam logic [7:0] LEN_LIMIT     = 8'd50;
  localparam logic [7:0] ACK_TAG_BYTE  = 8'hEF;
  localparam logic [7:0] ACK_LEN_BYTE  = 8'h02;
  localparam logic [7:0] FUNC_OUTER    = 8'h10;
  localparam logic [7:0] FUNC_INNER    = 8'h11;
  localparam logic [7:0] FUNC_GYRO     = 8'h15;
  localparam logic [7:0] ACK_HDR_SUM   =
    8'(HDR0_BYTE + HDR0_BYTE + ACK_TAG_BYTE + ACK_LEN_BYTE);

  // Last gain word index and last acknowledge byte index
  localparam logic [3:0] GAIN_LAST_IDX = 4'd8;
  localparam logic [2:0] ACK_LAST_IDX  = 3'd6;

  // Count and length register width
  localparam int CNT_W = 6;

  // Result kinds as seen on tuser
  typedef enum logic [1:0] {
    KIND_GAIN = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NOTE = 2'd2
  } res_kind_t;

  // Frame parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC    = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } parse_phase_t;

  // Result sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_RD_HI = 3'd1,
    SQ_RD_LO = 3'd2,
    SQ_GAIN  = 3'd3,
    SQ_ACK   = 3'd4,
    SQ_NOTE  = 3'd5
  } seq_state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic       rd_lo;
    logic       ld;
    res_kind_t  ld_kind;
    logic [3:0] gain_idx;
    logic [1:0] gain_axis;
    logic [1:0] gain_term;
    logic [2:0] ack_idx;
  } cfp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic fire;
    logic code_gain;
    logic code_ack;
    logic out_free;
  } cfp_sts_t;

  // Byte of the acknowledge frame at a given position
  function automatic logic [7:0] ack_byte_f(input logic [2:0] idx,
                                            input logic [7:0] code,
                                            input logic [7:0] sum);
    logic [7:0] res;
    res = 8'h00;
    unique case (idx)
      3'd0:    res = HDR0_BYTE;
      3'd1:    res = HDR0_BYTE;
      3'd2:    res = ACK_TAG_BYTE;
      3'd3:    res = ACK_LEN_BYTE;
      3'd4:    res = code;
      3'd5:    res = sum;
      3'd6:    res = 8'(ACK_HDR_SUM + code + sum);
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/command_frame_parser_with_ack_unit.sv -----
// Top level of the command frame parser with acknowledge.
`timescale 1ns / 1ps
// Takes one received byte per item and tracks frames AA AF, function, length,
// payload and an 8-bit additive checksum. A byte that does not fit a frame is
// taken and produces nothing. When the checksum byte matches, the block stops
// taking bytes and plays out its items from one output register: for functions
// 10h/11h nine gain words (two reads each through the single read port of the
// payload store), then for functions 10h to 15h seven acknowledge bytes, and
// always a closing notice with tlast set. The input stays held for the whole
// run, including any output stall. The payload store reads as zero until
// written after reset (one valid bit per entry, no clearing pass). Gain words
// are raw signed big-endian payload pairs; the consumer applies the 0.1 and
// 0.001 scaling.
module command_frame_parser_with_ack_unit #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] gain_bank, [2:1] gain_axis, [4:3] gain_term,
                                  // [20:5] gain_raw, [28:21] ack_byte,
                                  // [29] gyro_reinit, [31:30] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);
  import cfp_pkg::*;

  cfp_cmd_t           cmd;
  cfp_sts_t           sts;
  res_kind_t          kind;
  logic               bank;
  logic [1:0]         axis;
  logic [1:0]         term;
  logic signed [15:0] raw;
  logic [7:0]         ack;
  logic               gyro;

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfp_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (kind),
    .out_bank  (bank),
    .out_axis  (axis),
    .out_term  (term),
    .out_raw   (raw),
    .out_ack   (ack),
    .out_gyro  (gyro),
    .out_last  (out_tlast)
  );

  // Pack result fields, lowest first
  assign out_tdata = {2'b00, gyro, ack, raw, term, axis, bank};
  assign out_tuser = kind;

endmodule

// ----- rtl/cfp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cfp_ctrl.sv -----
// Result sequencer: input gating and ordering of gain, acknowledge and notice items.
`timescale 1ns / 1ps
module cfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfp_pkg::cfp_sts_t sts,
  output cfp_pkg::cfp_cmd_t cmd
);
  import cfp_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [3:0] gidx_r, gidx_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [1:0] term_r, term_nxt;
  logic [2:0] aidx_r, aidx_nxt;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      gidx_r  <= '0;
      axis_r  <= '0;
      term_r  <= '0;
      aidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      gidx_r  <= gidx_nxt;
      axis_r  <= axis_nxt;
      term_r  <= term_nxt;
      aidx_r  <= aidx_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    gidx_nxt  = gidx_r;
    axis_nxt  = axis_r;
    term_nxt  = term_r;
    aidx_nxt  = aidx_r;
    in_ready  = 1'b0;
    cmd           = '0;
    cmd.ld_kind   = KIND_GAIN;
    cmd.gain_idx  = gidx_r;
    cmd.gain_axis = axis_r;
    cmd.gain_term = term_r;
    cmd.ack_idx   = aidx_r;
    unique case (state_r)
      SQ_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        gidx_nxt = '0;
        axis_nxt = '0;
        term_nxt = '0;
        aidx_nxt = '0;
        if (in_valid && sts.fire) begin
          if (sts.code_gain) begin
            state_nxt = SQ_RD_HI;
          end else if (sts.code_ack) begin
            state_nxt = SQ_ACK;
          end else begin
            state_nxt = SQ_NOTE;
          end
        end
      end
      SQ_RD_HI: begin
        cmd.rd_en = 1'b1;
        state_nxt = SQ_RD_LO;
      end
      SQ_RD_LO: begin
        cmd.rd_en = 1'b1;
        cmd.rd_lo = 1'b1;
        state_nxt = SQ_GAIN;
      end
      SQ_GAIN: begin
        // Emit one gain word, then advance axis and term
        if (sts.out_free) begin
          cmd.ld      = 1'b1;
          cmd.ld_kind = KIND_GAIN;
          if (gidx_r == GAIN_LAST_IDX) begin
            state_nxt = SQ_ACK;
          end else begin
            gidx_nxt  = gidx_r + 4'd1;
            state_nxt = SQ_RD_HI;
            if (term_r == 2'd2) begin
              term_nxt = '0;
              axis_nxt = axis_r + 2'd1;
            end else begin
              term_nxt = term_r + 2'd1;
            end
          end
        end
      end
      SQ_ACK: begin
        if (sts.out_free) begin
          cmd.ld      = 1'b1;
          cmd.ld_kind = KIND_ACK;
          if (aidx_r == ACK_LAST_IDX) begin
            state_nxt = SQ_NOTE;
          end else begin
            aidx_nxt = aidx_r + 3'd1;
          end
        end
      end
      SQ_NOTE: begin
        if (sts.out_free) begin
          cmd.ld      = 1'b1;
          cmd.ld_kind = KIND_NOTE;
          state_nxt   = SQ_IDLE;
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/cfp_dp.sv -----
// Datapath: frame parse registers, payload store and the output register.
`timescale 1ns / 1ps
module cfp_dp #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  cfp_pkg::cfp_cmd_t  cmd,
  output cfp_pkg::cfp_sts_t  sts,
  input  logic               out_ready,
  output logic               out_valid,
  output cfp_pkg::res_kind_t out_kind,
  output logic               out_bank,
  output logic [1:0]         out_axis,
  output logic [1:0]         out_term,
  output logic signed [15:0] out_raw,
  output logic [7:0]         out_ack,
  output logic               out_gyro,
  output logic               out_last
);
  import cfp_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  parse_phase_t     phase_r, phase_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       func_r, func_nxt;
  logic             st_wr;
  logic             fire;

  logic [PAYLOAD_DEPTH-1:0] vld_r;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [4:0]       raddr_w;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic             rd_vld_r;
  logic [7:0]       rd_byte;
  logic [7:0]       hi_r;

  logic             out_valid_r;
  res_kind_t        kind_r;
  logic             bank_r;
  logic [1:0]       axis_r;
  logic [1:0]       term_r;
  logic [15:0]      raw_r;
  logic [7:0]       ack_r;
  logic             gyro_r;
  logic             last_r;

  // Parse registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rem_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      func_r  <= '0;
    end else if (cmd.take) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      func_r  <= func_nxt;
    end
  end

  // Advance the frame parser on one byte; drop anything unexpected
  always_comb begin
    phase_nxt = PH_HUNT;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    func_nxt  = func_r;
    st_wr     = 1'b0;
    fire      = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (in_byte == HDR0_BYTE) begin
          phase_nxt = PH_SYNC;
          sum_nxt   = HDR0_BYTE;
        end
      end
      PH_SYNC: begin
        if (in_byte == HDR1_BYTE) begin
          phase_nxt = PH_FUNC;
          sum_nxt   = sum_r + in_byte;
        end
      end
      PH_FUNC: begin
        if (in_byte < FUNC_LIMIT) begin
          phase_nxt = PH_LEN;
          func_nxt  = in_byte;
          sum_nxt   = sum_r + in_byte;
        end
      end
      PH_LEN: begin
        if (in_byte < LEN_LIMIT) begin
          phase_nxt = PH_PAYLOAD;
          rem_nxt   = in_byte[CNT_W-1:0];
          cnt_nxt   = '0;
          sum_nxt   = sum_r + in_byte;
        end
      end
      PH_PAYLOAD: begin
        // A zero length falls back to hunting on the next byte
        if (rem_r != '0) begin
          rem_nxt   = rem_r - CNT_W'(1);
          cnt_nxt   = cnt_r + CNT_W'(1);
          sum_nxt   = sum_r + in_byte;
          st_wr     = 1'b1;
          phase_nxt = (rem_r == CNT_W'(1)) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_CHECK: begin
        // Checksum byte lands in the store as well
        st_wr = 1'b1;
        fire  = (in_byte == sum_r);
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Store write, skipping indexes beyond the depth
  assign we    = cmd.take && st_wr && (32'(cnt_r) < 32'(PAYLOAD_DEPTH));
  assign waddr = AW'(cnt_r);

  // Valid bit per entry stands in for the cleared store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Read byte 2k or 2k+1 for gain word k
  assign raddr_w = {cmd.gain_idx, cmd.rd_lo};
  assign raddr   = AW'(raddr_w);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rd_byte = rd_vld_r ? rdata : 8'h00;

  // Hold the high byte while the low byte is read
  always_ff @(posedge clk) begin
    if (cmd.rd_lo) begin
      hi_r <= rd_byte;
    end
  end

  cfp_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_byte),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load one result item
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      kind_r <= cmd.ld_kind;
      bank_r <= 1'b0;
      axis_r <= '0;
      term_r <= '0;
      raw_r  <= '0;
      ack_r  <= '0;
      gyro_r <= 1'b0;
      last_r <= 1'b0;
      case (cmd.ld_kind)
        KIND_GAIN: begin
          bank_r <= (func_r == FUNC_INNER);
          axis_r <= cmd.gain_axis;
          term_r <= cmd.gain_term;
          raw_r  <= {hi_r, rd_byte};
        end
        KIND_ACK: begin
          ack_r <= ack_byte_f(cmd.ack_idx, func_r, sum_r);
        end
        default: begin
          gyro_r <= (func_r == FUNC_GYRO);
          last_r <= 1'b1;
        end
      endcase
    end
  end

  // Status toward the sequencer
  assign sts.fire      = fire;
  assign sts.code_gain = (func_r == FUNC_OUTER) || (func_r == FUNC_INNER);
  assign sts.code_ack  = (func_r >= FUNC_OUTER) && (func_r <= FUNC_GYRO);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_bank  = bank_r;
  assign out_axis  = axis_r;
  assign out_term  = term_r;
  assign out_raw   = $signed(raw_r);
  assign out_ack   = ack_r;
  assign out_gyro  = gyro_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/cfp_chk.sv -----
// Port-level checker for the command frame parser, bound to the top level.
`timescale 1ns / 1ps
module cfp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import cfp_pkg::*;

  // Output register is empty right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output item present after reset");

  // Only the notice closes a run
  a_last_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_NOTE)
    else $error("tlast on an item other than the notice");

  // Input is held while a run is still playing out
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("byte taken in the middle of a result run");

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output item changed");

endmodule

bind command_frame_parser_with_ack_unit cfp_chk u_cfp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/command_frame_parser_with_ack_unit_test.sv -----
// Self-checking testbench for the command frame parser with acknowledge.
`timescale 1ns / 1ps
module command_frame_parser_with_ack_unit_test;
  import cfp_pkg::*;

  localparam int BYTE_GOAL    = 170;
  localparam int MAX_GAP      = 14;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int STORE_DEPTH  = 64;
  localparam int PRINT_CAP    = 40;

  // One reply item as the block should present it
  typedef struct {
    res_kind_t   kind;
    logic        bank;
    logic [1:0]  axis;
    logic [1:0]  term;
    logic [15:0] raw;
    logic [7:0]  ack;
    logic        gyro;
    logic        last;
  } reply_t;

  // Ways of building a frame on the byte stream
  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_CUT
  } frame_mode_t;

  // Parse the byte stream alongside the block and hold the replies it owes
  class frame_reply_tracker;
    parse_phase_t phase;
    logic [5:0]   bytes_left;
    logic [5:0]   wr_idx;
    logic [7:0]   sum_acc;
    logic [7:0]   func;
    logic [7:0]   payload_mem [STORE_DEPTH];
    reply_t       queued_replies [$];
    int           mismatches;
    int           checked;
    int           gain_sets;
    int           ack_frames;
    int           notices;
    int           sum_drops;

    function new();
      phase      = PH_HUNT;
      bytes_left = '0;
      wr_idx     = '0;
      sum_acc    = '0;
      func       = '0;
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
    endfunction

    function void push_reply(res_kind_t kind, logic bank, logic [1:0] axis,
                             logic [1:0] term, logic [15:0] raw, logic [7:0] ack,
                             logic gyro, logic last);
      reply_t r;
      r.kind = kind;
      r.bank = bank;
      r.axis = axis;
      r.term = term;
      r.raw  = raw;
      r.ack  = ack;
      r.gyro = gyro;
      r.last = last;
      queued_replies.push_back(r);
    endfunction

    function int pending();
      return queued_replies.size();
    endfunction

    // Advance the frame parser by one accepted byte and queue its replies
    function void note_byte(logic [7:0] b);
      logic [7:0] ack_bytes [7];
      logic [7:0] ack_chk;
      if (phase == PH_HUNT && b == HDR0_BYTE) begin
        phase   = PH_SYNC;
        sum_acc = HDR0_BYTE;
      end else if (phase == PH_SYNC && b == HDR1_BYTE) begin
        phase   = PH_FUNC;
        sum_acc = sum_acc + b;
      end else if (phase == PH_FUNC && b < FUNC_LIMIT) begin
        phase   = PH_LEN;
        func    = b;
        sum_acc = sum_acc + b;
      end else if (phase == PH_LEN && b < LEN_LIMIT) begin
        phase      = PH_PAYLOAD;
        bytes_left = b[5:0];
        wr_idx     = '0;
        sum_acc    = sum_acc + b;
      end else if (phase == PH_PAYLOAD && bytes_left != 0) begin
        bytes_left          = bytes_left - 6'd1;
        payload_mem[wr_idx] = b;
        wr_idx              = wr_idx + 6'd1;
        sum_acc             = sum_acc + b;
        if (bytes_left == 0) phase = PH_CHECK;
      end else if (phase == PH_CHECK) begin
        // The checksum byte lands in the store even when it does not match
        phase               = PH_HUNT;
        payload_mem[wr_idx] = b;
        if (b != sum_acc) begin
          sum_drops++;
        end else begin
          // Gain words come from payload pairs, stale bytes included
          if (func == FUNC_OUTER || func == FUNC_INNER) begin
            gain_sets++;
            for (int k = 0; k < 9; k++) begin
              push_reply(KIND_GAIN, func == FUNC_INNER, 2'(k / 3), 2'(k % 3),
                         {payload_mem[2 * k], payload_mem[2 * k + 1]}, 8'h00, 1'b0, 1'b0);
            end
          end
          if (func >= FUNC_OUTER && func <= FUNC_GYRO) begin
            ack_frames++;
            ack_bytes = '{HDR0_BYTE, HDR0_BYTE, ACK_TAG_BYTE, ACK_LEN_BYTE,
                          func, sum_acc, 8'h00};
            ack_chk = 8'h00;
            for (int i = 0; i < 6; i++) ack_chk = ack_chk + ack_bytes[i];
            ack_bytes[6] = ack_chk;
            for (int i = 0; i < 7; i++) begin
              push_reply(KIND_ACK, 1'b0, 2'd0, 2'd0, 16'h0000, ack_bytes[i], 1'b0, 1'b0);
            end
          end
          notices++;
          push_reply(KIND_NOTE, 1'b0, 2'd0, 2'd0, 16'h0000, 8'h00,
                     func == FUNC_GYRO, 1'b1);
        end
      end else begin
        phase = PH_HUNT;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("mismatch at %0t ns, reply %0d: %s got %0h want %0h",
                 $time, checked, what, got, want);
    endtask

    // Compare one accepted reply with the oldest one owed
    task check_result(logic [1:0] user, logic [31:0] data, logic tlast);
      reply_t want;
      if (queued_replies.size() == 0) begin
        report_mismatch("reply with none owed, tdata", data, 32'h0);
        return;
      end
      want = queued_replies.pop_front();
      checked++;
      if (user != want.kind)         report_mismatch("kind", user, want.kind);
      if (data[0] != want.bank)      report_mismatch("gain_bank", data[0], want.bank);
      if (data[2:1] != want.axis)    report_mismatch("gain_axis", data[2:1], want.axis);
      if (data[4:3] != want.term)    report_mismatch("gain_term", data[4:3], want.term);
      if (data[20:5] != want.raw)    report_mismatch("gain_raw", data[20:5], want.raw);
      if (data[28:21] != want.ack)   report_mismatch("ack_byte", data[28:21], want.ack);
      if (data[29] != want.gyro)     report_mismatch("gyro_reinit", data[29], want.gyro);
      if (tlast != want.last)        report_mismatch("last", tlast, want.last);
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_reply_tracker sb = new();

  bit in_burst     = 1'b0;
  bit out_burst    = 1'b0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int idle_cycles  = 0;

  command_frame_parser_with_ack_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Build a frame with random payload, then break it as asked
  task automatic send_frame(input logic [7:0] code, input logic [7:0] len,
                            input frame_mode_t mode);
    logic [7:0] frame_bytes [$];
    logic [7:0] chk;
    int         body;
    int         keep;
    frame_bytes = '{HDR0_BYTE, HDR1_BYTE, code, len};
    // An out-of-range length leaves the parser hunting; a few bytes suffice
    body = (len < LEN_LIMIT) ? int'(len) : 3;
    for (int i = 0; i < body; i++) begin
      case ($urandom_range(0, 7))
        0:       frame_bytes.push_back(8'h00);
        1:       frame_bytes.push_back(8'hFF);
        2:       frame_bytes.push_back(8'h7F);
        3:       frame_bytes.push_back(8'h80);
        default: frame_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    chk = 8'h00;
    foreach (frame_bytes[i]) chk = chk + frame_bytes[i];
    if (mode == FR_BAD_SUM) chk = chk ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(chk);
    if (mode == FR_CUT) begin
      keep = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    frames_sent++;
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // Check every reply the block hands over
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  // Stall the reply side by a random count per item, with stall-free stretches
  initial begin : reply_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Count cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles, %0d replies still owed",
             STALL_LIMIT, sb.pending());
    $display("command_frame_parser_with_ack_unit regression: fail");
    $finish;
  end

  // Reset, directed frames, random frames, drain, verdict
  initial begin : stimulus
    logic [7:0] code;
    logic [7:0] len;
    int         pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Byte extremes, a second header byte where the sync byte belongs
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR0_BYTE);
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    // Zero length aborts on the next byte
    send_frame(FUNC_GYRO, 8'd0, FR_GOOD);
    // Short inner gain frame reads stale store and its own checksum byte
    send_frame(FUNC_INNER, 8'd2, FR_GOOD);
    // Highest legal code, which only earns the notice
    send_frame(8'hF0, 8'd1, FR_GOOD);

    while (bytes_sent < BYTE_GOAL) begin
      in_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: code = FUNC_OUTER;
        3, 4:    code = FUNC_INNER;
        5, 6, 7: code = 8'($urandom_range(8'h12, 8'h15));
        8:       code = 8'($urandom_range(0, 8'hF0));
        default: code = 8'hF0;
      endcase
      if ($urandom_range(0, 11) == 0)
        len = 8'd49;
      else if ((code == FUNC_OUTER || code == FUNC_INNER) && $urandom_range(0, 1) == 1)
        len = 8'd18;
      else
        len = 8'($urandom_range(0, 20));
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_frame(code, len, FR_GOOD);
      else if (pick < 72)
        send_frame(code, len, FR_BAD_SUM);
      else if (pick < 82)
        send_frame(code, len, FR_CUT);
      else if (pick < 87)
        send_frame(8'($urandom_range(8'hF1, 8'hFF)), len, FR_GOOD);
      else if (pick < 92)
        send_frame(code, 8'($urandom_range(50, 255)), FR_GOOD);
      else
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
    in_tvalid <= 1'b0;

    // Drain owed replies, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d frames; %0d gain sets, %0d acks, %0d notices, %0d bad sums",
             bytes_sent, frames_sent, sb.gain_sets, sb.ack_frames, sb.notices, sb.sum_drops);
    $display("checked %0d replies, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("command_frame_parser_with_ack_unit regression: pass");
    end else begin
      $display("command_frame_parser_with_ack_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cfp_pkg.sv
rtl/cfp_ram.sv
rtl/cfp_ctrl.sv
rtl/cfp_dp.sv
rtl/command_frame_parser_with_ack_unit.sv
rtl/cfp_chk.sv
tb/command_frame_parser_with_ack_unit_test.sv
